// ===== rtl/core/cmdp_pkg.sv =====
`default_nettype none
package cmdp_pkg;

	localparam int MAX_MSG_LEN_DEF = 128;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 16;
	localparam int ACC_W   = VALUE_W + 1;

	// Command codes on the result channel
	typedef enum logic [2:0] {
		CMD_UNKNOWN = 3'd0,
		CMD_MAC     = 3'd1,
		CMD_ID      = 3'd2,
		CMD_STATUS  = 3'd3,
		CMD_DEC     = 3'd4
	} cmd_code_t;

	// Argument parser state
	typedef enum logic [2:0] {
		RM_START = 3'd0,
		RM_ZERO  = 3'd1,
		RM_BIN   = 3'd2,
		RM_HEX   = 3'd3,
		RM_OCT   = 3'd4,
		RM_LEAD  = 3'd5,
		RM_DIG   = 3'd6,
		RM_DONE  = 3'd7
	} rm_t;

	// Per-character strobes from the line control to the word and argument units
	typedef struct packed {
		logic word_en;
		logic arg_en;
		logic clear;
	} step_t;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

endpackage
`default_nettype wire

// ===== rtl/core/cmdp_word.sv =====
`default_nettype none
module cmdp_word
	import cmdp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire step_t             ctl,
	input  wire logic [CHAR_W-1:0] ch,
	output cmd_code_t              code
);

	logic [5:0][CHAR_W-1:0] chars_q, chars_d;
	logic [2:0]             len_q, len_d;
	logic [CHAR_W-1:0]      lc;

	always_comb begin
		lc = ch;
		if (ch inside {[8'h41:8'h5A]}) begin
			lc = ch + 8'd32;
		end
		chars_d = chars_q;
		len_d   = len_q;
		if (ctl.word_en) begin
			for (int i = 0; i < 6; i++) begin
				if (len_q == 3'(i)) begin
					chars_d[i] = lc;
				end
			end
			if (len_q != 3'd7) begin
				len_d = len_q + 3'd1;
			end
		end
	end

	// match on the updated word so the final character counts
	always_comb begin
		code = CMD_UNKNOWN;
		if (len_d == 3'd3 && chars_d[0] == "m" && chars_d[1] == "a" && chars_d[2] == "c") begin
			code = CMD_MAC;
		end else if (len_d == 3'd2 && chars_d[0] == "i" && chars_d[1] == "d") begin
			code = CMD_ID;
		end else if (len_d == 3'd6 && chars_d[0] == "s" && chars_d[1] == "t" &&
		             chars_d[2] == "a" && chars_d[3] == "t" && chars_d[4] == "u" &&
		             chars_d[5] == "s") begin
			code = CMD_STATUS;
		end else if (len_d == 3'd3 && chars_d[0] == "d" && chars_d[1] == "e" &&
		             chars_d[2] == "c") begin
			code = CMD_DEC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			len_q   <= '0;
		end else if (ctl.clear) begin
			chars_q <= '0;
			len_q   <= '0;
		end else begin
			chars_q <= chars_d;
			len_q   <= len_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/cmdp_arg.sv =====
`default_nettype none
module cmdp_arg
	import cmdp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire step_t              ctl,
	input  wire logic [CHAR_W-1:0]  ch,
	output logic      [VALUE_W-1:0] value,
	output logic                    bad
);

	typedef enum logic [1:0] {
		RAD_BIN = 2'd0,
		RAD_OCT = 2'd1,
		RAD_DEC = 2'd2,
		RAD_HEX = 2'd3
	} radix_t;

	localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(1) << VALUE_W;

	// digit value, 16 when not a digit of that radix
	function automatic logic [4:0] digit_of(input logic [CHAR_W-1:0] c, input radix_t r);
		logic [4:0] d;
		logic [4:0] lim;
		d = 5'd16;
		if (c inside {[8'h30:8'h39]}) begin
			d = 5'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			d = 5'(c - 8'h61 + 8'd10);
		end else if (c inside {[8'h41:8'h46]}) begin
			d = 5'(c - 8'h41 + 8'd10);
		end
		case (r)
			RAD_BIN: lim = 5'd2;
			RAD_OCT: lim = 5'd8;
			RAD_DEC: lim = 5'd10;
			RAD_HEX: lim = 5'd16;
			default: lim = 5'd16;
		endcase
		return (d < lim) ? d : 5'd16;
	endfunction

	// acc * radix + d, saturating at 65536
	function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] a, input radix_t r,
	                                               input logic [3:0] d);
		logic [ACC_W+3:0] w;
		logic [ACC_W+3:0] p;
		w = (ACC_W+4)'(a);
		case (r)
			RAD_BIN: p = w << 1;
			RAD_OCT: p = w << 3;
			RAD_DEC: p = (w << 3) + (w << 1);
			RAD_HEX: p = w << 4;
			default: p = w;
		endcase
		p = p + (ACC_W+4)'(d);
		return (p > (ACC_W+4)'(ACC_SAT - 1)) ? ACC_SAT : p[ACC_W-1:0];
	endfunction

	rm_t              mode_q, mode_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic             err_q, err_d;
	logic             neg_q, neg_d;
	logic             is_ws, is_dig, is_sign;
	logic [4:0]       dg;
	radix_t           rsel;

	always_comb begin
		is_ws   = (ch == CH_SPACE) || (ch inside {[8'h09:8'h0D]});
		is_dig  = ch inside {[8'h30:8'h39]};
		is_sign = (ch == "+") || (ch == "-");
		case (mode_q)
			RM_BIN:  rsel = RAD_BIN;
			RM_HEX:  rsel = RAD_HEX;
			RM_DIG, RM_START, RM_LEAD: rsel = RAD_DEC;
			default: rsel = RAD_OCT;
		endcase
		dg = digit_of(ch, rsel);

		mode_d = mode_q;
		acc_d  = acc_q;
		err_d  = err_q;
		neg_d  = neg_q;
		if (ctl.arg_en) begin
			case (mode_q)
				RM_START: begin
					if (ch == "0") begin
						mode_d = RM_ZERO;
					end else if (is_sign) begin
						neg_d  = (ch == "-");
						mode_d = RM_DIG;
					end else if (is_dig) begin
						acc_d  = acc_step(acc_q, RAD_DEC, dg[3:0]);
						mode_d = RM_DIG;
					end else if (is_ws) begin
						mode_d = RM_LEAD;
					end else begin
						mode_d = RM_DONE;
					end
				end
				RM_ZERO: begin
					if (ch == "b") begin
						mode_d = RM_BIN;
					end else if (ch == "x") begin
						mode_d = RM_HEX;
					end else begin
						mode_d = RM_OCT;
						if (!dg[4]) begin
							acc_d = acc_step(acc_q, RAD_OCT, dg[3:0]);
						end else begin
							err_d = 1'b1;
						end
					end
				end
				RM_BIN, RM_HEX, RM_OCT: begin
					if (!err_q) begin
						if (!dg[4]) begin
							acc_d = acc_step(acc_q, rsel, dg[3:0]);
						end else begin
							err_d = 1'b1;
						end
					end
				end
				RM_LEAD: begin
					if (is_ws) begin
						mode_d = RM_LEAD;
					end else if (is_sign) begin
						neg_d  = (ch == "-");
						mode_d = RM_DIG;
					end else if (is_dig) begin
						acc_d  = acc_step(acc_q, RAD_DEC, dg[3:0]);
						mode_d = RM_DIG;
					end else begin
						mode_d = RM_DONE;
					end
				end
				RM_DIG: begin
					if (is_dig) begin
						acc_d = acc_step(acc_q, RAD_DEC, dg[3:0]);
					end else begin
						mode_d = RM_DONE;
					end
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end

		bad   = err_d || acc_d[VALUE_W] || (neg_d && (acc_d != '0));
		value = bad ? '0 : acc_d[VALUE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RM_START;
			acc_q  <= '0;
			err_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else if (ctl.clear) begin
			mode_q <= RM_START;
			acc_q  <= '0;
			err_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			err_q  <= err_d;
			neg_q  <= neg_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/command_line_number_parser.sv =====
`default_nettype none
// Command line parser: takes a line one character per request on the s_axis
// channel (tlast marks the final character) and returns one result request per
// line on the m_axis channel: command code (unknown, mac, id, status, dec) and,
// for dec, the parsed argument value with an error flag.
// Argument forms: 0b binary, 0x hex, leading 0 octal, otherwise decimal with
// optional leading whitespace and sign. Values above 65535, bad 0b/0x/octal
// digits and nonzero negatives set the error flag and force the value to zero.
// A NUL character ends the line text; later characters up to tlast are ignored.
// Lines of MAX_MSG_LEN or more characters report the unknown command.
// Throughput: one character per cycle while no final character waits on a result.
// The only per-character loop is the accumulator multiply-add, done by shifts.
// Path: an accepted character is registered in the input stage and processed
// from there; when the final character leaves the input stage the result is
// registered and shows on m_axis from then on.
// Stall: while a result waits on m_axis, non-final characters keep flowing;
// a final character waits in the input stage until the result is taken.
// Reset (arst_n low) clears all line state and drops both valids.
module command_line_number_parser
	import cmdp_pkg::*;
#(
	parameter int MAX_MSG_LEN = MAX_MSG_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_in
	input  wire logic        s_axis_tlast,  // last_char
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata   // [2:0] command_code, [18:3] parsed_value,
	                                        // [19] value_error, [23:20] zero
);

	localparam int LEN_W = $clog2(MAX_MSG_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MSG_LEN);

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// line control
	logic              nul_seen_q;
	logic              in_arg_q;
	logic [LEN_W-1:0]  line_len_q, line_len_d;

	// result register
	logic               out_valid_q;
	cmd_code_t          code_q;
	logic [VALUE_W-1:0] value_q;
	logic               err_q;

	logic               step;
	logic               active;
	logic               split;
	step_t              ctl;
	cmd_code_t          word_code;
	logic [VALUE_W-1:0] arg_value;
	logic               arg_bad;
	cmd_code_t          code_d;

	// a final character moves only when the result register is free
	assign step = valid_s1 && !(last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_comb begin
		active      = step && !nul_seen_q && (char_s1 != CH_NUL);
		split       = active && !in_arg_q && ((char_s1 == CH_SPACE) || (char_s1 == CH_TAB));
		ctl.word_en = active && !in_arg_q && !split;
		ctl.arg_en  = active && in_arg_q;
		ctl.clear   = step && last_s1;
		line_len_d  = line_len_q;
		if (active && line_len_q < LEN_MAX) begin
			line_len_d = line_len_q + LEN_W'(1);
		end
		code_d = (line_len_d >= LEN_MAX) ? CMD_UNKNOWN : word_code;
	end

	cmdp_word u_word (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.ch     (char_s1),
		.code   (word_code)
	);

	cmdp_arg u_arg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.ch     (char_s1),
		.value  (arg_value),
		.bad    (arg_bad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_seen_q <= 1'b0;
			in_arg_q   <= 1'b0;
			line_len_q <= '0;
		end else if (ctl.clear) begin
			nul_seen_q <= 1'b0;
			in_arg_q   <= 1'b0;
			line_len_q <= '0;
		end else begin
			if (step && !nul_seen_q && char_s1 == CH_NUL) begin
				nul_seen_q <= 1'b1;
			end
			if (split) begin
				in_arg_q <= 1'b1;
			end
			line_len_q <= line_len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			code_q  <= code_d;
			value_q <= (code_d == CMD_DEC) ? arg_value : '0;
			err_q   <= (code_d == CMD_DEC) ? arg_bad : 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, err_q, value_q, code_q};

endmodule
`default_nettype wire
